// ===== rtl/tked_pkg.sv =====
// ----------------------------------------------------------------------------
// tked_pkg
// Types and constants for the terminal key escape decoder.
// ----------------------------------------------------------------------------
package tked_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_INTRO = 3'd2,
        PH_NUM   = 3'd3,
        PH_SEMI  = 3'd4,
        PH_MOD   = 3'd5
    } t_phase;

    typedef logic [8:0] t_key;

    localparam t_key KEY_ESC        = 9'd27;
    localparam t_key KEY_UP         = 9'd256;
    localparam t_key KEY_HOME       = 9'd260;
    localparam t_key KEY_END        = 9'd261;
    localparam t_key KEY_DEL        = 9'd262;
    localparam t_key KEY_PGUP       = 9'd263;
    localparam t_key KEY_PGDN       = 9'd264;
    localparam t_key KEY_CTRL_BASE  = 9'd265;
    localparam t_key KEY_SHIFT_BASE = 9'd269;
    localparam t_key KEY_LAST       = 9'd272;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_SS3   = 8'h4f;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

endpackage

// ===== rtl/terminal_key_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_unit
// Decodes terminal bytes and read timeouts into key codes, one item a cycle while the input is not stalled.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                  payload
//   in        sink        i_in_valid / o_in_stall    i_command, i_rx_byte
//   out       source      o_out_valid / i_out_stall  o_key_code
//
// One item is taken per cycle while the input does not stall; its key code,
// if any, shows in the next cycle from the result register. The parse state
// updates in the accepting cycle. The input stalls only while the result
// register holds an item and the output stalls. Synchronous reset returns
// the parser to idle and empties the result register.
module terminal_key_escape_decoder_unit
    import tked_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [8:0] o_key_code
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_intro, n_intro;
    logic [7:0] r_number, n_number;
    logic [7:0] r_modifier, n_modifier;
    logic       r_out_valid, n_out_valid;
    t_key       r_key, n_key;

    logic       in_accept;
    logic       emit;
    t_key       key;
    logic       is_arrow;
    logic [1:0] arrow_off;
    logic       is_digit;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_key;

    assign is_arrow  = (i_rx_byte >= CH_A) && (i_rx_byte <= CH_D);
    assign arrow_off = 2'(i_rx_byte - CH_A);
    assign is_digit  = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);

    always_comb begin
        n_phase    = r_phase;
        n_intro    = r_intro;
        n_number   = r_number;
        n_modifier = r_modifier;
        emit       = 1'b0;
        key        = KEY_ESC;
        if (r_phase == PH_IDLE) begin
            if (i_command == CMD_BYTE) begin
                if (i_rx_byte == CH_ESC) begin
                    n_phase = PH_ESC;
                end else begin
                    emit = 1'b1;
                    key  = {1'b0, i_rx_byte};
                end
            end
        end else if (i_command == CMD_TIMEOUT) begin
            n_phase = PH_IDLE;
            emit    = 1'b1;
        end else begin
            unique case (r_phase)
                PH_ESC: begin
                    n_intro = i_rx_byte;
                    n_phase = PH_INTRO;
                end
                PH_INTRO: begin
                    if (r_intro == CH_LBRK && is_digit) begin
                        n_number = i_rx_byte;
                        n_phase  = PH_NUM;
                    end else begin
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                        if (r_intro == CH_LBRK || r_intro == CH_SS3) begin
                            if (r_intro == CH_LBRK && is_arrow) begin
                                key = KEY_UP + t_key'(arrow_off);
                            end else if (i_rx_byte == CH_H) begin
                                key = KEY_HOME;
                            end else if (i_rx_byte == CH_F) begin
                                key = KEY_END;
                            end
                        end
                    end
                end
                PH_NUM: begin
                    if (i_rx_byte == CH_SEMI) begin
                        n_phase = PH_SEMI;
                    end else begin
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                        if (i_rx_byte == CH_TILDE) begin
                            case (r_number)
                                CH_1, CH_7: key = KEY_HOME;
                                CH_3:       key = KEY_DEL;
                                CH_4, CH_8: key = KEY_END;
                                CH_5:       key = KEY_PGUP;
                                CH_6:       key = KEY_PGDN;
                                default:    key = KEY_ESC;
                            endcase
                        end
                    end
                end
                PH_SEMI: begin
                    n_modifier = i_rx_byte;
                    n_phase    = PH_MOD;
                end
                PH_MOD: begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                    if (is_arrow && r_modifier == CH_5) begin
                        key = KEY_CTRL_BASE + t_key'(arrow_off);
                    end else if (is_arrow && r_modifier == CH_2) begin
                        key = KEY_SHIFT_BASE + t_key'(arrow_off);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_key       = r_key;
        if (in_accept && emit) begin
            n_out_valid = 1'b1;
            n_key       = key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_intro     <= '0;
            r_number    <= '0;
            r_modifier  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_accept) begin
                r_phase    <= n_phase;
                r_intro    <= n_intro;
                r_number   <= n_number;
                r_modifier <= n_modifier;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    a_plain_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_phase == PH_IDLE && i_command == CMD_BYTE && i_rx_byte != CH_ESC
        |=> o_out_valid && o_key_code == {1'b0, $past(i_rx_byte)})
        else $error("plain byte not passed through");

    a_idle_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_phase == PH_IDLE && i_command == CMD_TIMEOUT
        |=> r_phase == PH_IDLE && o_out_valid == $past(r_out_valid && i_out_stall))
        else $error("idle timeout produced an item");

    a_seq_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_phase != PH_IDLE && i_command == CMD_TIMEOUT
        |=> r_phase == PH_IDLE && o_out_valid && o_key_code == KEY_ESC)
        else $error("timeout in sequence did not yield escape");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_code <= KEY_LAST)
        else $error("key code out of range");

endmodule

// ===== verif/tb_terminal_key_escape_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terminal_key_escape_decoder_unit
// Feeds the escape decoder a table of directed bytes and timeouts, then a long
// run of random key sequences, many of them well formed, some cut short by a
// timeout or spoiled by a stray byte, mixed with plain bytes. A model of the
// parser in this file predicts each key code, and the results are compared in
// order. The sender works in bursts and the receiver stalls on varying
// patterns, with one long hold-off and several drains of the decoder.
// ----------------------------------------------------------------------------
module tb_terminal_key_escape_decoder_unit;
    import tked_pkg::*;

    localparam int N_DIR  = 25;
    localparam int N_RAND = 1025;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       fixed;
        logic       has_key;
        t_key       key;
        logic       drain;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_command   = CMD_BYTE;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [8:0] o_key_code;

    t_key      key_fifo [$];
    t_stim_row stim_q [$];
    int        err_cnt      = 0;
    int        accepted_cnt = 0;

    t_phase     prs_phase = PH_IDLE;
    logic [7:0] prs_intro = 8'h00;
    logic [7:0] prs_num   = 8'h00;
    logic [7:0] prs_mod   = 8'h00;

    t_stim_row dir_tab [N_DIR] = '{
        '{CMD_TIMEOUT, 8'hff,    1'b1, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    8'h00,    1'b1, 1'b1, 9'd0,    1'b0},
        '{CMD_BYTE,    8'hff,    1'b1, 1'b1, 9'd255,  1'b0},
        '{CMD_BYTE,    8'h80,    1'b1, 1'b1, 9'd128,  1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b1, 1'b0, 9'd0,    1'b0},
        '{CMD_TIMEOUT, 8'h00,    1'b1, 1'b1, KEY_ESC, 1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b0, 1'b0, 9'd0,    1'b1},
        '{CMD_BYTE,    CH_LBRK,  1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_A,     1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_SS3,   1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_H,     1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_LBRK,  1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_5,     1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_TILDE, 1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_LBRK,  1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_1,     1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_SEMI,  1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_5,     1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_D,     1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    CH_ESC,   1'b0, 1'b0, 9'd0,    1'b0},
        '{CMD_BYTE,    8'h78,    1'b1, 1'b1, KEY_ESC, 1'b0}
    };

    terminal_key_escape_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_key_code  (o_key_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] mostly(input logic [7:0] good);
        return ($urandom_range(0, 15) == 0) ? 8'($urandom) : good;
    endfunction

    function automatic bit decode_key(input logic cmd, input logic [7:0] b, output t_key key);
        bit got;
        key = KEY_ESC;
        got = 1'b1;
        if (prs_phase == PH_IDLE) begin
            if (cmd == CMD_TIMEOUT) begin
                got = 1'b0;
            end else if (b == CH_ESC) begin
                prs_phase = PH_ESC;
                got = 1'b0;
            end else begin
                key = {1'b0, b};
            end
        end else if (cmd == CMD_TIMEOUT) begin
            prs_phase = PH_IDLE;
        end else begin
            case (prs_phase)
                PH_ESC: begin
                    prs_intro = b;
                    prs_phase = PH_INTRO;
                    got = 1'b0;
                end
                PH_INTRO: begin
                    if (prs_intro == CH_LBRK && b >= CH_0 && b <= CH_9) begin
                        prs_num = b;
                        prs_phase = PH_NUM;
                        got = 1'b0;
                    end else begin
                        prs_phase = PH_IDLE;
                        if (prs_intro == CH_LBRK && b >= CH_A && b <= CH_D)
                            key = KEY_UP + t_key'(b - CH_A);
                        else if ((prs_intro == CH_LBRK || prs_intro == CH_SS3) && b == CH_H)
                            key = KEY_HOME;
                        else if ((prs_intro == CH_LBRK || prs_intro == CH_SS3) && b == CH_F)
                            key = KEY_END;
                    end
                end
                PH_NUM: begin
                    if (b == CH_SEMI) begin
                        prs_phase = PH_SEMI;
                        got = 1'b0;
                    end else begin
                        prs_phase = PH_IDLE;
                        if (b == CH_TILDE) begin
                            case (prs_num)
                                CH_1, CH_7: key = KEY_HOME;
                                CH_3:       key = KEY_DEL;
                                CH_4, CH_8: key = KEY_END;
                                CH_5:       key = KEY_PGUP;
                                CH_6:       key = KEY_PGDN;
                                default:    key = KEY_ESC;
                            endcase
                        end
                    end
                end
                PH_SEMI: begin
                    prs_mod = b;
                    prs_phase = PH_MOD;
                    got = 1'b0;
                end
                default: begin
                    prs_phase = PH_IDLE;
                    if (b >= CH_A && b <= CH_D) begin
                        if (prs_mod == CH_5)
                            key = KEY_CTRL_BASE + t_key'(b - CH_A);
                        else if (prs_mod == CH_2)
                            key = KEY_SHIFT_BASE + t_key'(b - CH_A);
                    end
                end
            endcase
        end
        return got;
    endfunction

    initial begin : sender
        int k, r, shape, cut, gap, burst, seq_cnt, wait_cnt;
        bit got;
        t_key key;
        logic [8:0] seq [$];
        t_stim_row row;

        for (k = 0; k < N_DIR; k++) stim_q.push_back(dir_tab[k]);
        seq_cnt = 0;
        while (stim_q.size() < N_DIR + N_RAND) begin
            seq.delete();
            shape = $urandom_range(0, 9);
            r = $urandom_range(0, 5);
            case (shape)
                0, 1: seq.push_back({CMD_BYTE, 8'($urandom)});
                2, 3: begin
                    seq.push_back({CMD_BYTE, CH_ESC});
                    seq.push_back({CMD_BYTE, mostly(CH_LBRK)});
                    seq.push_back({CMD_BYTE,
                        mostly((r < 4) ? CH_A + 8'(r) : (r == 4) ? CH_H : CH_F)});
                end
                4: begin
                    seq.push_back({CMD_BYTE, CH_ESC});
                    seq.push_back({CMD_BYTE, mostly(CH_SS3)});
                    seq.push_back({CMD_BYTE,
                        mostly((r < 2) ? CH_H : (r < 4) ? CH_F : CH_A + 8'(r - 4))});
                end
                5, 6: begin
                    seq.push_back({CMD_BYTE, CH_ESC});
                    seq.push_back({CMD_BYTE, mostly(CH_LBRK)});
                    seq.push_back({CMD_BYTE, CH_0 + 8'($urandom_range(0, 9))});
                    seq.push_back({CMD_BYTE, mostly(CH_TILDE)});
                end
                7, 8: begin
                    seq.push_back({CMD_BYTE, CH_ESC});
                    seq.push_back({CMD_BYTE, mostly(CH_LBRK)});
                    seq.push_back({CMD_BYTE, CH_0 + 8'($urandom_range(0, 9))});
                    seq.push_back({CMD_BYTE, mostly(CH_SEMI)});
                    seq.push_back({CMD_BYTE, (r < 2) ? CH_5 : (r < 4) ? CH_2 : 8'($urandom)});
                    seq.push_back({CMD_BYTE, mostly(CH_A + 8'($urandom_range(0, 3)))});
                end
                default: begin
                    seq.push_back({CMD_BYTE, CH_ESC});
                    seq.push_back({CMD_BYTE, 8'($urandom)});
                    seq.push_back({CMD_BYTE, 8'($urandom)});
                end
            endcase
            // cut the sequence short with a timeout
            if (seq.size() > 1 && $urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, seq.size() - 1);
                while (seq.size() > cut) void'(seq.pop_back());
                seq.push_back({CMD_TIMEOUT, 8'($urandom)});
            end
            if ($urandom_range(0, 11) == 0) seq.push_back({CMD_TIMEOUT, 8'($urandom)});
            seq_cnt++;
            foreach (seq[j]) begin
                row = '0;
                row.cmd = seq[j][8];
                row.data = seq[j][7:0];
                row.drain = (j == 0 && seq_cnt % 80 == 0);
                stim_q.push_back(row);
            end
        end

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        burst = 0;
        for (k = 0; k < stim_q.size(); k++) begin
            row = stim_q[k];
            // hold off until the decoder has delivered everything
            if (row.drain) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (key_fifo.size() != 0) @(posedge i_clk);
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst--;
            i_in_valid <= 1'b1;
            i_command  <= row.cmd;
            i_rx_byte  <= row.data;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            got = decode_key(row.cmd, row.data, key);
            if (row.fixed) begin
                got = row.has_key;
                key = row.key;
            end
            if (got) key_fifo.push_back(key);
            accepted_cnt++;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        wait_cnt = 0;
        while (key_fifo.size() != 0 && wait_cnt < 5000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (8) @(posedge i_clk);
        if (key_fifo.size() != 0) begin
            $display("%0t ns: %0d key codes missing, expected %0d next, actual none",
                     $time, key_fifo.size(), key_fifo[0]);
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : receiver
        int mode, span, hold, tick;
        bit held_long;
        held_long = 1'b0;
        tick = 0;
        forever begin
            // long hold-off so the decoder fills and stalls its input
            if (!held_long && accepted_cnt >= 400) begin
                held_long = 1'b1;
                for (hold = 0; hold < 200; hold++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 1);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= (tick % 3 == 0);
                endcase
                tick++;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (key_fifo.size() == 0) begin
                $display("%0t ns: key_code expected none, actual %0d", $time, o_key_code);
                err_cnt++;
            end else begin
                if (o_key_code !== key_fifo[0]) begin
                    $display("%0t ns: key_code expected %0d, actual %0d",
                             $time, key_fifo[0], o_key_code);
                    err_cnt++;
                end
                void'(key_fifo.pop_front());
            end
        end
    end

endmodule
